FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL of the level meter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/srlm_pkg.sv
// ----------------------------------------------------------------------------
// srlm_pkg
// Types and constants of the stereo RMS level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package srlm_pkg;

    localparam int SMP_W   = 16;   // input sample, Q1.15
    localparam int MAG_W   = 15;   // magnitude of a halved sample
    localparam int ROOT_W  = 15;   // rms, Q0.15
    localparam int SQ_W    = 2 * ROOT_W;  // mean square fed to the root
    localparam int ALPHA_W = 16;
    localparam int FS_W    = 15;
    localparam int FRAC_W  = 16;   // extra fraction bits of the average
    localparam int ACC_W   = ROOT_W + FRAC_W + 1;
    localparam int PROD_W  = ALPHA_W + ACC_W;
    localparam int DEN_W   = FS_W + FRAC_W + 1;
    localparam int LEVEL_W = 16;
    localparam int BUF_W   = 32;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd4588;
    localparam logic [FS_W-1:0]    FS_RESET    = 15'd5571;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 16'hFFFF;
    // largest average: rms of 16384 with 16 fraction bits
    localparam logic [ACC_W-1:0]   ACC_MAX     = 32'h4000_0000;

    // register index, taken from paddr[2]
    localparam logic REG_ALPHA      = 1'b0;
    localparam logic REG_FULL_SCALE = 1'b1;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_sample;
        logic signed [SMP_W-1:0] right_sample;
        logic                    last_frame;
    } t_in_item;

    typedef struct packed {
        logic [ROOT_W-1:0]  buffer_rms;
        logic [ROOT_W-1:0]  smoothed_level;
        logic [LEVEL_W-1:0] scaled_level;
        logic [BUF_W-1:0]   buffers_seen;
        logic               frames_dropped;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_L,
        S_SQ_R,
        S_SQ_ADD,
        S_DIV_MEAN,
        S_WAIT_MEAN,
        S_WAIT_ROOT,
        S_DIFF,
        S_MUL,
        S_UPD,
        S_DIV_SCL,
        S_WAIT_SCL,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: design/srlm_divider.sv
// ----------------------------------------------------------------------------
// srlm_divider
// Restoring divider, one quotient bit per cycle, shared by the mean and
// the full-scale division.
// ----------------------------------------------------------------------------
`default_nettype none

module srlm_divider #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;   // dividend bits shift out, quotient bits in
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] rem_sub;
    logic           ge;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

FILE: design/srlm_isqrt.sv
// ----------------------------------------------------------------------------
// srlm_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srlm_isqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [srlm_pkg::SQ_W-1:0] i_val,
    output logic                           o_done,
    output logic [srlm_pkg::ROOT_W-1:0]    o_root
);

    import srlm_pkg::*;

    localparam int REM_W = ROOT_W + 1;
    localparam int CNT_W = $clog2(ROOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SQ_W-1:0]   r_val;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {r_rem, r_val[SQ_W-1 -: 2]};
        trial   = (REM_W + 2)'({r_root, 2'b01});
        rem_sub = rem_sh - trial;
        ge      = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[SQ_W-3:0], 2'b00};
            // remainder stays at most twice the root, so REM_W bits suffice
            r_rem  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: design/stereo_rms_level_meter_core.sv
// ----------------------------------------------------------------------------
// stereo_rms_level_meter_core
// Stereo frames come in on the input channel (valid/ready); a frame marked
// last closes the buffer and one result goes out on the output channel.
// A frame is taken in S_IDLE and then uses the shared multiplier
// in S_SQ_L (left square), S_SQ_R (right square) and S_SQ_ADD
// (final add); the next frame is taken only back in S_IDLE. A last
// frame adds the end-of-buffer pass: a 48-step mean division, a
// 15-step square root, the smoothing multiply and a second 48-step
// division for the scaled level. The two divisions share one
// restoring divider. The input is not ready during that pass.
// The result sits in an output register; a new buffer may be taken while
// it waits. If the receiver still stalls at the end of the next buffer,
// the sequencer holds until the transfer frees the register.
// Reset clears sums, the average and the buffer count, and loads the
// register defaults. Registers must be written by the user over the APB
// port only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stereo_rms_level_meter_core #(
    parameter int MAX_FRAMES = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire srlm_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output srlm_pkg::t_out_item                o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [srlm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [srlm_pkg::APB_W-1:0]    pwdata,
    output logic [srlm_pkg::APB_W-1:0]         prdata,
    output logic                               pready
);

    import srlm_pkg::*;

    localparam int CNT_W = $clog2(2 * MAX_FRAMES + 1);
    localparam int SUM_W = 30 + $clog2(MAX_FRAMES);
    localparam int NUM_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(2 * MAX_FRAMES);

    t_state r_state, n_state;

    logic [ALPHA_W-1:0] r_alpha;
    logic [FS_W-1:0]    r_fs;
    t_in_item           r_in;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [ACC_W-1:0]   r_acc;
    logic [BUF_W-1:0]   r_bufs;
    logic [PROD_W-1:0]  r_prod;
    logic [ROOT_W-1:0]  r_rms;
    logic               r_up;
    logic [ACC_W-1:0]   r_diff;
    logic [LEVEL_W-1:0] r_scaled;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_fire;
    logic               full;
    logic               out_load;
    logic               cfg_wr;
    logic [ALPHA_W-1:0] mul_a;
    logic [ACC_W-1:0]   mul_b;
    logic [MAG_W-1:0]   mag_l, mag_r;
    logic [ACC_W-1:0]   target;
    logic [FS_W-1:0]    fs_eff;
    logic [PROD_W-1:0]  scl_num;
    logic [PROD_W:0]    dn_round;

    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_num, div_quot;
    logic [DEN_W-1:0]   div_den;
    logic               rt_start, rt_done;
    logic [SQ_W-1:0]    rt_val;
    logic [ROOT_W-1:0]  rt_root;

    // |floor(s/2)|, at most 16384
    function automatic logic [MAG_W-1:0] half_mag(input logic signed [SMP_W-1:0] s);
        logic signed [SMP_W-1:0] h;
        logic [SMP_W-1:0]        m;
        h = s >>> 1;
        m = h[SMP_W-1] ? (~h + 1'b1) : h;
        return m[MAG_W-1:0];
    endfunction

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_fs    <= FS_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ALPHA:      r_alpha <= pwdata[ALPHA_W-1:0];
                REG_FULL_SCALE: r_fs    <= pwdata[FS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ALPHA:      prdata = APB_W'(r_alpha);
            REG_FULL_SCALE: prdata = APB_W'(r_fs);
            default:        prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign in_fire  = i_in_valid & o_in_ready;
    assign full     = (r_count >= CNT_FULL);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        rt_start   = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!full) begin
                        n_state = S_SQ_L;
                    end else if (i_in_data.last_frame) begin
                        n_state = S_DIV_MEAN;
                    end
                end
            end
            S_SQ_L:   n_state = S_SQ_R;
            S_SQ_R:   n_state = S_SQ_ADD;
            S_SQ_ADD: n_state = r_in.last_frame ? S_DIV_MEAN : S_IDLE;
            S_DIV_MEAN: begin
                div_start = 1'b1;
                n_state   = S_WAIT_MEAN;
            end
            S_WAIT_MEAN: begin
                if (div_done) begin
                    rt_start = 1'b1;
                    n_state  = S_WAIT_ROOT;
                end
            end
            S_WAIT_ROOT: if (rt_done) begin
                n_state = S_DIFF;
            end
            S_DIFF: n_state = S_MUL;
            S_MUL:  n_state = S_UPD;
            S_UPD:  n_state = S_DIV_SCL;
            S_DIV_SCL: begin
                div_start = 1'b1;
                n_state   = S_WAIT_SCL;
            end
            S_WAIT_SCL: if (div_done) begin
                n_state = S_OUT;
            end
            S_OUT: if (out_load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- shared multiplier ----------------
    assign mag_l = half_mag(r_in.left_sample);
    assign mag_r = half_mag(r_in.right_sample);

    always_comb begin
        case (r_state)
            S_SQ_L: begin
                mul_a = ALPHA_W'(mag_l);
                mul_b = ACC_W'(mag_l);
            end
            S_SQ_R: begin
                mul_a = ALPHA_W'(mag_r);
                mul_b = ACC_W'(mag_r);
            end
            default: begin
                mul_a = r_alpha;
                mul_b = r_diff;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // ---------------- divider and root ----------------
    assign fs_eff  = (r_fs == '0) ? FS_W'(1) : r_fs;
    // acc * 65535 as (acc << 16) - acc
    assign scl_num = {r_acc, {FRAC_W{1'b0}}} - PROD_W'(r_acc);

    always_comb begin
        if (r_state == S_DIV_MEAN) begin
            div_num = NUM_W'(r_sum);
            div_den = DEN_W'(r_count);
        end else begin
            div_num = NUM_W'(scl_num);
            div_den = DEN_W'({fs_eff, {FRAC_W{1'b0}}});
        end
    end

    // mean square never exceeds 16384^2; empty count gives zero
    assign rt_val = (r_count == '0) ? '0 : div_quot[SQ_W-1:0];

    srlm_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    srlm_isqrt u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rt_start),
        .i_val   (rt_val),
        .o_done  (rt_done),
        .o_root  (rt_root)
    );

    // ---------------- datapath ----------------
    assign target   = {1'b0, r_rms, {FRAC_W{1'b0}}};
    // downward step rounds toward minus infinity
    assign dn_round = {1'b0, r_prod} + (PROD_W + 1)'({FRAC_W{1'b1}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_acc   <= '0;
            r_bufs  <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (in_fire) begin
                    if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_count <= r_count + CNT_W'(2);
                    end
                end
                S_SQ_R, S_SQ_ADD: r_sum <= r_sum + SUM_W'(r_prod);
                S_UPD: begin
                    if (r_up) begin
                        r_acc <= r_acc + r_prod[PROD_W-1 -: ACC_W];
                    end else begin
                        r_acc <= r_acc - dn_round[FRAC_W +: ACC_W];
                    end
                end
                S_OUT: if (out_load) begin
                    r_sum   <= '0;
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_bufs  <= r_bufs + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
        if (rt_done) begin
            r_rms <= rt_root;
        end
        if (r_state == S_DIFF) begin
            r_up   <= (target >= r_acc);
            r_diff <= (target >= r_acc) ? (target - r_acc) : (r_acc - target);
        end
        if (r_state == S_WAIT_SCL && div_done) begin
            r_scaled <= (div_quot[NUM_W-1:LEVEL_W] != '0) ? LEVEL_MAX
                                                         : div_quot[LEVEL_W-1:0];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.buffer_rms     <= r_rms;
            r_out.smoothed_level <= r_acc[ACC_W-2 -: ROOT_W];
            r_out.scaled_level   <= r_scaled;
            r_out.buffers_seen   <= r_bufs + 1'b1;
            r_out.frames_dropped <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL)
    `ASSERT_ALWAYS(a_acc_bound, i_clk, i_rst_n, r_acc <= ACC_MAX)
    `ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, out_load, r_out_valid && r_state == S_IDLE)
    `ASSERT_NEXT(a_buf_cleared, i_clk, i_rst_n, out_load, r_count == '0 && r_sum == '0 && !r_ovf)

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo RMS level meter core. A queue of stereo
// frames feeds a valid/ready driver, and a monitor predicts every buffer
// result (rms, smoothed level, scaled level, buffer count, drop flag) as
// frames transfer. Each result out of the block is compared field by field.
// Registers are set over APB between phases while the meter is idle, and
// the sender and receiver idle at random in several patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import srlm_pkg::*;

    localparam int FRAME_LIMIT  = 256;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              in_valid  = 1'b0;
    t_in_item          in_data   = '0;
    logic              in_ready;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_item         out_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [APB_W-1:0]  pwdata    = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    t_in_item  frame_queue[$];
    t_out_item level_expected[$];
    logic      in_taken      = 1'b0;
    int        stall_cycles  = 0;
    int        error_count   = 0;
    int        send_idle_pct = 10;
    int        recv_idle_pct = 58;

    // predictor copy of registers and state
    logic [ALPHA_W-1:0] alpha_reg      = ALPHA_RESET;
    logic [FS_W-1:0]    full_scale_reg = FS_RESET;
    longint unsigned    sq_sum         = 0;
    int unsigned        samples_in_buf = 0;
    longint unsigned    avg_acc        = 0;
    logic [BUF_W-1:0]   buf_count      = '0;
    logic               frames_lost    = 1'b0;

    stereo_rms_level_meter_core #(
        .MAX_FRAMES(FRAME_LIMIT)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // Adds one frame to the buffer sums unless the buffer is full; on a last frame returns the result.
    function automatic bit meter_frame(input t_in_item f, output t_out_item r);
        int              lh;
        int              rh;
        longint unsigned mean;
        longint unsigned root;
        longint unsigned target;
        longint unsigned fs;
        longint unsigned scaled;
        r = '0;
        if (samples_in_buf / 2 < FRAME_LIMIT) begin
            lh = $signed(f.left_sample);
            rh = $signed(f.right_sample);
            lh = lh >>> 1;
            rh = rh >>> 1;
            if (lh < 0) lh = -lh;
            if (rh < 0) rh = -rh;
            sq_sum += lh * lh + rh * rh;
            samples_in_buf += 2;
        end else begin
            frames_lost = 1'b1;
        end
        if (!f.last_frame) return 1'b0;

        mean = (samples_in_buf != 0) ? sq_sum / samples_in_buf : 0;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= mean)
                root |= 64'd1 << b;
        end

        // step rounds toward minus infinity in both directions
        target = root << FRAC_W;
        if (target >= avg_acc)
            avg_acc += (64'(alpha_reg) * (target - avg_acc)) >> FRAC_W;
        else
            avg_acc -= (64'(alpha_reg) * (avg_acc - target) + 64'hFFFF) >> FRAC_W;
        avg_acc &= 64'h7FFF_FFFF;

        fs = (full_scale_reg != 0) ? 64'(full_scale_reg) : 64'd1;
        scaled = avg_acc * 64'd65535 / (fs << FRAC_W);
        if (scaled > 64'(LEVEL_MAX)) scaled = 64'(LEVEL_MAX);
        buf_count += 1;

        r.buffer_rms     = root[ROOT_W-1:0];
        r.smoothed_level = avg_acc[FRAC_W +: ROOT_W];
        r.scaled_level   = scaled[LEVEL_W-1:0];
        r.buffers_seen   = buf_count;
        r.frames_dropped = frames_lost;
        sq_sum         = 0;
        samples_in_buf = 0;
        frames_lost    = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_frame(input logic [SMP_W-1:0] l, input logic [SMP_W-1:0] r,
                              input logic last);
        t_in_item f;
        f.left_sample  = l;
        f.right_sample = r;
        f.last_frame   = last;
        frame_queue.insert(frame_queue.size(), f);
    endtask

    // one buffer of random frames, sometimes attenuated so the average falls
    task automatic queue_buffer(input int frames);
        int                      shift;
        logic signed [SMP_W-1:0] l;
        logic signed [SMP_W-1:0] r;
        shift = ($urandom_range(2) == 0) ? $urandom_range(15) : 0;
        for (int k = 0; k < frames; k++) begin
            l = pick_sample();
            r = pick_sample();
            push_frame(l >>> shift, r >>> shift, k == frames - 1);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [APB_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_ALPHA)
            alpha_reg = value[ALPHA_W-1:0];
        else
            full_scale_reg = value[FS_W-1:0];
    endtask

    // hold off until every result is back and the end-of-buffer pass is over
    task automatic settle();
        while (frame_queue.size() != 0 || in_valid || level_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (frame_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= frame_queue.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                if (meter_frame(in_data, want))
                    level_expected.insert(level_expected.size(), want);
            end

            if (out_valid && out_ready) begin
                if (level_expected.size() == 0) begin
                    error_count++;
                    $display("%0t: expected no result, got rms %0d count %0d",
                             $time, out_data.buffer_rms, out_data.buffers_seen);
                end else begin
                    want = level_expected.pop_front();
                    if (out_data !== want) begin
                        error_count++;
                        if (out_data.buffer_rms !== want.buffer_rms)
                            $display("%0t: buffer_rms expected %0d got %0d",
                                     $time, want.buffer_rms, out_data.buffer_rms);
                        if (out_data.smoothed_level !== want.smoothed_level)
                            $display("%0t: smoothed_level expected %0d got %0d",
                                     $time, want.smoothed_level,
                                     out_data.smoothed_level);
                        if (out_data.scaled_level !== want.scaled_level)
                            $display("%0t: scaled_level expected %0d got %0d",
                                     $time, want.scaled_level, out_data.scaled_level);
                        if (out_data.buffers_seen !== want.buffers_seen)
                            $display("%0t: buffers_seen expected %0d got %0d",
                                     $time, want.buffers_seen, out_data.buffers_seen);
                        if (out_data.frames_dropped !== want.frames_dropped)
                            $display("%0t: frames_dropped expected %0d got %0d",
                                     $time, want.frames_dropped,
                                     out_data.frames_dropped);
                    end
                end
            end

            // only counts while work is outstanding
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (!in_valid && frame_queue.size() == 0 && level_expected.size() == 0)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("stereo_rms_level_meter_core verification failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int n;
        int len;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: zero, full-scale negative and positive, minus one
        // halving to minus one, plus and minus one, mixed multi-frame buffer
        push_frame(16'h0000, 16'h0000, 1'b1);
        push_frame(16'h8000, 16'h8000, 1'b1);
        push_frame(16'h7FFF, 16'h7FFF, 1'b1);
        push_frame(16'hFFFF, 16'hFFFF, 1'b1);
        push_frame(16'h0001, 16'hFFFF, 1'b1);
        push_frame(16'h8000, 16'h7FFF, 1'b0);
        push_frame(16'h0000, 16'h8000, 1'b0);
        push_frame(16'h7FFF, 16'h0001, 1'b1);
        settle();

        // fastest average: jump to the top, then fall back
        write_reg(REG_ALPHA, 32'h0000_FFFF);
        write_reg(REG_FULL_SCALE, 32'h0000_4000);
        push_frame(16'h8000, 16'h8000, 1'b1);
        push_frame(16'h0000, 16'h0000, 1'b1);
        push_frame(16'h7FFF, 16'h8000, 1'b1);
        push_frame(16'h0000, 16'h0000, 1'b1);
        settle();

        // frozen average with the smallest full scale
        write_reg(REG_ALPHA, 32'h0000_0000);
        write_reg(REG_FULL_SCALE, 32'h0000_0001);
        push_frame(16'h8000, 16'h8000, 1'b1);
        push_frame(16'h1234, 16'hEDCC, 1'b1);
        settle();

        // full scale of zero acts as one
        write_reg(REG_ALPHA, 32'h0000_8000);
        write_reg(REG_FULL_SCALE, 32'h0000_0000);
        push_frame(16'h8000, 16'h8000, 1'b1);
        push_frame(16'h0000, 16'h0000, 1'b1);
        settle();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 58 : 0;
            recv_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 10 : 0;
            for (int ph = 0; ph < 3; ph++) begin
                case ($urandom_range(4))
                    0: write_reg(REG_ALPHA, 32'h0000_0000);
                    1: write_reg(REG_ALPHA, 32'h0000_FFFF);
                    2: write_reg(REG_ALPHA, $urandom_range(1, 4096));
                    default: write_reg(REG_ALPHA, $urandom_range(0, 65535));
                endcase
                case ($urandom_range(3))
                    0: write_reg(REG_FULL_SCALE, 32'd1);
                    1: write_reg(REG_FULL_SCALE, 32'd16384);
                    default: write_reg(REG_FULL_SCALE, $urandom_range(1, 16384));
                endcase
                // buffers past the frame limit, the frames beyond it dropped
                if (mode * 3 + ph == 1) queue_buffer(FRAME_LIMIT + 1);
                if (mode * 3 + ph == 7) queue_buffer(FRAME_LIMIT + 5);
                n = 0;
                while (n < 14) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
                    queue_buffer(len);
                    n += len;
                end
                settle();
            end
        end

        if (error_count == 0)
            $display("stereo_rms_level_meter_core verification clean");
        else
            $display("stereo_rms_level_meter_core verification failed");
        $finish;
    end

endmodule
